// ===== design/mono_frame_buffer_bit_blitter_macros.svh =====
// Assertion macros for the frame buffer blitter controller
`ifndef MONO_FRAME_BUFFER_BIT_BLITTER_MACROS_SVH
`define MONO_FRAME_BUFFER_BIT_BLITTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MFBB_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MFBB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mfbb_pkg.sv =====
// Shared types, constants and mask helpers for the frame buffer blitter
package mfbb_pkg;

  localparam int DATA_W         = 16;
  localparam int STORE_WORDS    = 65536;
  localparam int ADDR_W         = $clog2(STORE_WORDS);
  localparam int WORDS_PER_LINE = 64;
  localparam int LINE_SH        = $clog2(WORDS_PER_LINE);
  localparam int X_W            = DATA_W + 1;
  localparam int WID_W          = 12;
  localparam int LN_W           = 14;

  localparam logic [2:0] ACT_REG_WR   = 3'd0;
  localparam logic [2:0] ACT_REG_RD   = 3'd1;
  localparam logic [2:0] ACT_MEM_WR   = 3'd2;
  localparam logic [2:0] ACT_MEM_RD   = 3'd3;
  localparam logic [2:0] ACT_VB_START = 3'd4;
  localparam logic [2:0] ACT_VB_END   = 3'd5;

  localparam logic [15:0] REG_CTRL = 16'd0;
  localparam logic [15:0] REG_DEB  = 16'd1;
  localparam logic [15:0] REG_SY   = 16'd2;
  localparam logic [15:0] REG_SX   = 16'd3;
  localparam logic [15:0] REG_DCY  = 16'd4;
  localparam logic [15:0] REG_DCX  = 16'd5;
  localparam logic [15:0] REG_DY   = 16'd6;
  localparam logic [15:0] REG_DX   = 16'd7;

  // Control word bit positions
  localparam int CTL_GO      = 15;
  localparam int CTL_FRM_IRQ = 5;
  localparam int CTL_BLT_IRQ = 4;
  localparam int CTL_INC_Y   = 3;
  localparam int CTL_INC_X   = 2;
  localparam int CTL_FILL    = 1;

  localparam logic [15:0] STAT_EOF = 16'h0080;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [15:0] write_mask;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_raised;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_CAPTURE, ST_REG_WR, ST_MEM_RD, ST_MEM_WR, ST_VB_START,
    ST_VB_END, ST_BLT_ADJ, ST_BLT_LINE, ST_BLT_RSRC, ST_BLT_RD1, ST_BLT_RD2,
    ST_BLT_WR1, ST_BLT_WR2, ST_BLT_ADV
  } step_t;

  typedef struct packed {
    step_t step;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       go;
    logic       width_pos;
    logic       split;
    logic       chunk_last;
    logic       last_line;
    logic       clr_done;
  } dp_status_t;

  function automatic logic [15:0] ones_low(input logic [4:0] k);
    logic [16:0] t;
    t = (17'd1 << k) - 17'd1;
    if (k >= 5'd16) return 16'hffff;
    return t[15:0];
  endfunction

  function automatic logic [15:0] ones_high(input logic [4:0] n);
    return ~ones_low(5'd16 - n);
  endfunction

endpackage

// ===== design/mono_frame_buffer_bit_blitter.sv =====
// Top level: monochrome frame buffer with bit-block-transfer engine
// Register, vblank and memory read accesses pass through capture, decode and result states;
// memory writes add a write state (read-modify-write on the frame store).
// A blit adjusts the origins, then walks each line in chunks: each chunk reads source and two
// destination words and writes one or two, one store access per cycle.
// One item at a time; the next is taken once the previous result has been transferred.
// After reset a clearing pass zeroes the frame store before the first item.
module mono_frame_buffer_bit_blitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfbb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mfbb_pkg::out_item_t out_data
);
  import mfbb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mfbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mfbb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== design/mfbb_dp.sv =====
// Datapath: registers, frame store, blit address and merge logic, result register
module mfbb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mfbb_pkg::in_item_t  in_data,
  input  mfbb_pkg::ctrl_cmd_t cmd,
  output mfbb_pkg::dp_status_t status,
  output mfbb_pkg::out_item_t out_data
);
  import mfbb_pkg::*;

  logic [DATA_W-1:0] mem [STORE_WORDS];

  logic [15:0] ctrl_r, deb_r, sy_r, sx_r, dcy_r, dcx_r, dy_r, dx_r;
  logic        eof_r;
  in_item_t    item_r;
  logic [X_W-1:0]    bsx_r, bdx_r;
  logic [WID_W-1:0]  left_r, width_r;
  logic [LN_W-1:0]   ln_r, lines_r;
  logic [15:0]       sw_r, d1_r, d2w_r, rdata_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  out_item_t         out_r;

  logic [4:0]  soff, avail, n, skip, room, second;
  logic [15:0] ys, yd;
  logic [ADDR_W-1:0] src_idx, dst_idx, raddr, waddr;
  logic        we;
  logic [15:0] wdata, sw_shift, keep, rd_mux;
  logic [WID_W-1:0] width_calc;
  logic [LN_W-1:0]  lines_calc;
  logic        irq;

  assign soff  = {1'b0, bsx_r[3:0]};
  assign avail = 5'd16 - soff;
  assign n     = (left_r < {{(WID_W-5){1'b0}}, avail}) ? left_r[4:0] : avail;
  assign skip  = {1'b0, bdx_r[3:0]};
  assign room  = 5'd16 - skip;
  assign second = n - room;
  assign ys = sy_r + 16'(ln_r);
  assign yd = dy_r + 16'(ln_r);
  assign src_idx = ADDR_W'({ys, LINE_SH'(0)}) + ADDR_W'(bsx_r[X_W-1:4]);
  assign dst_idx = ADDR_W'({yd, LINE_SH'(0)}) + ADDR_W'(bdx_r[X_W-1:4]);
  assign sw_shift = ctrl_r[CTL_FILL] ? 16'h0000 : ((rdata_r << soff[3:0]) & ones_high(n));
  assign keep = (n > room) ? ones_high(skip) : (ones_high(skip) | ones_low(room - n));

  assign width_calc = WID_W'({7'd1 + {1'b0, ~dcx_r[5:0]}, 4'b0000}) - WID_W'(dx_r[3:0])
                      - WID_W'(15) + WID_W'(deb_r[3:0]);
  assign lines_calc = {1'b0, ~dcy_r[12:0]} + LN_W'(1);

  assign status.action     = item_r.action;
  assign status.go         = (item_r.address == REG_CTRL) && item_r.write_data[CTL_GO];
  assign status.width_pos  = !width_r[WID_W-1] && (width_r != '0);
  assign status.split      = n > room;
  assign status.chunk_last = left_r <= {{(WID_W-5){1'b0}}, n};
  assign status.last_line  = ln_r == (lines_r - LN_W'(1));
  assign status.clr_done   = &clr_cnt_r;

  always_comb begin
    raddr = item_r.address[ADDR_W-1:0];
    we    = 1'b0;
    waddr = dst_idx;
    wdata = (d1_r & keep) | (sw_r >> skip[3:0]);
    case (cmd.step)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
      end
      ST_MEM_WR: begin
        we    = 1'b1;
        waddr = item_r.address[ADDR_W-1:0];
        wdata = (rdata_r & ~item_r.write_mask) | (item_r.write_data & item_r.write_mask);
      end
      ST_BLT_RSRC: raddr = src_idx;
      ST_BLT_RD1:  raddr = dst_idx;
      ST_BLT_RD2:  raddr = dst_idx + ADDR_W'(1);
      ST_BLT_WR1:  we = 1'b1;
      ST_BLT_WR2: begin
        we    = 1'b1;
        waddr = dst_idx + ADDR_W'(1);
        wdata = d2w_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    rd_mux = '0;
    case (item_r.action)
      ACT_REG_RD: begin
        case (item_r.address)
          REG_CTRL: rd_mux = eof_r ? STAT_EOF : 16'h0000;
          REG_DEB:  rd_mux = deb_r;
          REG_SY:   rd_mux = sy_r;
          REG_SX:   rd_mux = sx_r;
          REG_DCY:  rd_mux = dcy_r;
          REG_DCX:  rd_mux = dcx_r;
          REG_DY:   rd_mux = dy_r;
          REG_DX:   rd_mux = dx_r;
          default:  rd_mux = '0;
        endcase
      end
      ACT_MEM_RD: rd_mux = rdata_r;
      default:    rd_mux = '0;
    endcase
    irq = ((item_r.action == ACT_REG_WR) && status.go && ctrl_r[CTL_BLT_IRQ]) ||
          ((item_r.action == ACT_VB_START) && ctrl_r[CTL_FRM_IRQ]);
  end

  // Control and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      deb_r     <= '0;
      sy_r      <= '0;
      sx_r      <= '0;
      dcy_r     <= '0;
      dcx_r     <= '0;
      dy_r      <= '0;
      dx_r      <= '0;
      eof_r     <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      case (cmd.step)
        ST_CLR: clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        ST_REG_WR: begin
          case (item_r.address)
            REG_CTRL: ctrl_r <= item_r.write_data;
            REG_DEB:  deb_r  <= item_r.write_data;
            REG_SY:   sy_r   <= item_r.write_data;
            REG_SX:   sx_r   <= item_r.write_data;
            REG_DCY:  dcy_r  <= item_r.write_data;
            REG_DCX:  dcx_r  <= item_r.write_data;
            REG_DY:   dy_r   <= item_r.write_data;
            REG_DX:   dx_r   <= item_r.write_data;
            default: ;
          endcase
        end
        ST_VB_START: if (ctrl_r[CTL_FRM_IRQ]) eof_r <= 1'b1;
        ST_VB_END:   eof_r <= 1'b0;
        ST_BLT_ADJ: begin
          // Decrementing directions move the origins back and keep them
          if (!ctrl_r[CTL_INC_X]) begin
            sx_r <= sx_r - {{(16-WID_W){width_r[WID_W-1]}}, width_r};
            dx_r <= dx_r - {{(16-WID_W){width_r[WID_W-1]}}, width_r};
          end
          if (!ctrl_r[CTL_INC_Y]) begin
            sy_r <= sy_r - 16'(lines_r);
            dy_r <= dy_r - 16'(lines_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture, blit walk and result payload
  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_CAPTURE: item_r <= in_data;
      ST_REG_WR: begin
        width_r <= width_calc;
        lines_r <= lines_calc;
      end
      ST_BLT_ADJ: ln_r <= '0;
      ST_BLT_LINE: begin
        bsx_r  <= {1'b0, sx_r};
        bdx_r  <= {1'b0, dx_r};
        left_r <= width_r;
      end
      ST_BLT_RD1: sw_r <= sw_shift;
      ST_BLT_RD2: d1_r <= rdata_r;
      ST_BLT_WR1: d2w_r <= (rdata_r & ones_low(5'd16 - second)) | (sw_r << room[3:0]);
      ST_BLT_ADV: begin
        bsx_r  <= bsx_r + X_W'(n);
        bdx_r  <= bdx_r + X_W'(n);
        left_r <= left_r - WID_W'(n);
        if (status.chunk_last) ln_r <= ln_r + LN_W'(1);
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_r.read_data  <= rd_mux;
      out_r.irq_raised <= irq;
    end
  end

  assign out_data = out_r;

endmodule

// ===== design/mfbb_ctrl.sv =====
// Controller: sequences bus accesses, the clearing pass and the blit walk
module mfbb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mfbb_pkg::dp_status_t status,
  output mfbb_pkg::ctrl_cmd_t  cmd
);
  import mfbb_pkg::*;
  `include "mono_frame_buffer_bit_blitter_macros.svh"

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_MWR, S_ADJ, S_LINE, S_RSRC, S_RD1, S_RD2, S_WR1, S_WR2,
    S_ADV, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.step     = ST_IDLE;
    cmd.out_load = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLR: begin
        cmd.step = ST_CLR;
        if (status.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.step  = ST_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        case (status.action)
          ACT_REG_WR: begin
            cmd.step = ST_REG_WR;
            if (status.go) state_nxt = S_ADJ;
          end
          ACT_MEM_WR: begin
            cmd.step  = ST_MEM_RD;
            state_nxt = S_MWR;
          end
          ACT_MEM_RD:   cmd.step = ST_MEM_RD;
          ACT_VB_START: cmd.step = ST_VB_START;
          ACT_VB_END:   cmd.step = ST_VB_END;
          default: ;
        endcase
      end
      S_MWR: begin
        cmd.step  = ST_MEM_WR;
        state_nxt = S_OUT;
      end
      S_ADJ: begin
        cmd.step  = ST_BLT_ADJ;
        state_nxt = status.width_pos ? S_LINE : S_OUT;
      end
      S_LINE: begin
        cmd.step  = ST_BLT_LINE;
        state_nxt = S_RSRC;
      end
      S_RSRC: begin
        cmd.step  = ST_BLT_RSRC;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.step  = ST_BLT_RD1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.step  = ST_BLT_RD2;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        cmd.step  = ST_BLT_WR1;
        state_nxt = status.split ? S_WR2 : S_ADV;
      end
      S_WR2: begin
        cmd.step  = ST_BLT_WR2;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        cmd.step = ST_BLT_ADV;
        if (!status.chunk_last) state_nxt = S_RSRC;
        else if (status.last_line) state_nxt = S_OUT;
        else state_nxt = S_LINE;
      end
      S_OUT: begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MFBB_ASSERT_IMM(a_accept_only_idle, !in_stall, state_r == S_IDLE, "transfer taken outside idle")
  `MFBB_ASSERT_NXT(a_accept_decodes, in_valid && !in_stall, state_r == S_DEC, "accepted item not decoded")
  `MFBB_ASSERT_NXT(a_out_loaded, state_r == S_OUT, out_valid_r, "result not presented")
  `MFBB_ASSERT_IMM(a_wr2_after_wr1, state_r == S_WR2, $past(state_r) == S_WR1, "second write out of order")

endmodule

// ===== tb/sv/tb_mono_frame_buffer_bit_blitter.sv =====
// Self-checking testbench for the monochrome frame buffer blitter: bus accesses, blits, vblank
module tb_mono_frame_buffer_bit_blitter;
  import mfbb_pkg::*;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  mono_frame_buffer_bit_blitter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block's state
  bit [15:0] fb_shadow [0:STORE_WORDS-1];
  logic [15:0] ctl_q, deb_q, sy_q, sx_q, dcy_q, dcx_q, dy_q, dx_q;
  logic [1:0] status_q;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int blits_run = 0;
  int irqs_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  function automatic int mask_low(int n);
    if (n >= 16) return 16'hffff;
    if (n <= 0) return 0;
    return (1 << n) - 1;
  endfunction

  function automatic int mask_high(int n);
    return ~mask_low(16 - (n > 16 ? 16 : n)) & 16'hffff;
  endfunction

  function automatic int store_word(longint x, longint y);
    return int'((y * WORDS_PER_LINE + x / 16) % STORE_WORDS);
  endfunction

  // Copy or zero-fill the rectangle; returns the blit interrupt
  function automatic bit blit_shadow();
    int lines, words, width, left, soff, n, skip, dw, dw2, sw, v, a, b, fb, sb;
    longint sxx, syy, dxx, dyy;
    bit fill;
    lines = 1 + (~dcy_q & 16'h1fff);
    words = 1 + (~dcx_q & 16'h003f);
    width = 16 * words - (dx_q % 16) - 15 + (deb_q & 16'hf);
    fill = ctl_q[CTL_FILL];
    if (!ctl_q[CTL_INC_X]) begin
      sx_q = sx_q - width[15:0];
      dx_q = dx_q - width[15:0];
    end
    if (!ctl_q[CTL_INC_Y]) begin
      sy_q = sy_q - lines[15:0];
      dy_q = dy_q - lines[15:0];
    end
    for (int ln = 0; ln < lines; ln++) begin
      sxx = sx_q; syy = longint'(sy_q) + ln;
      dxx = dx_q; dyy = longint'(dy_q) + ln;
      left = width;
      while (left > 0) begin
        soff = int'(sxx % 16);
        n = 16 - soff;
        skip = int'(dxx % 16);
        dw = store_word(dxx, dyy);
        if (left < n) n = left;
        sw = fill ? 0 : int'(fb_shadow[store_word(sxx, syy)]);
        sw = ((sw << soff) & 16'hffff) & mask_high(n);
        if (n <= 16 - skip) begin
          v = fb_shadow[dw];
          v &= mask_high(skip) | mask_low(16 - skip - n);
          v |= sw >> skip;
          fb_shadow[dw] = v[15:0];
        end else begin
          fb = 16 - skip;
          sb = n - fb;
          dw2 = (dw + 1) % STORE_WORDS;
          a = fb_shadow[dw] & mask_high(skip);
          b = fb_shadow[dw2] & mask_low(16 - sb);
          a |= sw >> skip;
          b |= (sw << fb) & 16'hffff;
          fb_shadow[dw] = a[15:0];
          fb_shadow[dw2] = b[15:0];
        end
        sxx += n;
        dxx += n;
        left -= n;
      end
    end
    return ctl_q[CTL_BLT_IRQ];
  endfunction

  function automatic out_item_t access_result(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.action)
      ACT_REG_WR:
        case (it.address)
          REG_CTRL: begin
            ctl_q = it.write_data;
            if (it.write_data[CTL_GO]) begin
              r.irq_raised = blit_shadow();
              blits_run++;
            end
          end
          REG_DEB: deb_q = it.write_data;
          REG_SY:  sy_q = it.write_data;
          REG_SX:  sx_q = it.write_data;
          REG_DCY: dcy_q = it.write_data;
          REG_DCX: dcx_q = it.write_data;
          REG_DY:  dy_q = it.write_data;
          REG_DX:  dx_q = it.write_data;
          default: ;
        endcase
      ACT_REG_RD:
        case (it.address)
          REG_CTRL: r.read_data = (status_q[1] ? 16'h8000 : 16'h0) | (status_q[0] ? STAT_EOF : 16'h0);
          REG_DEB: r.read_data = deb_q;
          REG_SY:  r.read_data = sy_q;
          REG_SX:  r.read_data = sx_q;
          REG_DCY: r.read_data = dcy_q;
          REG_DCX: r.read_data = dcx_q;
          REG_DY:  r.read_data = dy_q;
          REG_DX:  r.read_data = dx_q;
          default: ;
        endcase
      ACT_MEM_WR:
        fb_shadow[it.address] = (fb_shadow[it.address] & ~it.write_mask) |
                                (it.write_data & it.write_mask);
      ACT_MEM_RD: r.read_data = fb_shadow[it.address];
      ACT_VB_START:
        if (ctl_q[CTL_FRM_IRQ]) begin
          status_q[0] = 1'b1;
          r.irq_raised = 1'b1;
        end
      ACT_VB_END: status_q[0] = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_item(logic [2:0] act, logic [15:0] addr, logic [15:0] data,
                           logic [15:0] mask);
    in_item_t it;
    it.action = act;
    it.address = addr;
    it.write_data = data;
    it.write_mask = mask;
    pending_items.push_back(it);
  endtask

  task automatic reg_wr(logic [15:0] idx, logic [15:0] data);
    push_item(ACT_REG_WR, idx, data, 16'($urandom));
  endtask

  task automatic set_rect(logic [15:0] deb, logic [15:0] sy, logic [15:0] sx,
                          logic [15:0] dcy, logic [15:0] dcx, logic [15:0] dy,
                          logic [15:0] dx);
    reg_wr(REG_DEB, deb); reg_wr(REG_SY, sy); reg_wr(REG_SX, sx);
    reg_wr(REG_DCY, dcy); reg_wr(REG_DCX, dcx); reg_wr(REG_DY, dy); reg_wr(REG_DX, dx);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver
  int in_gap = 0;
  bit calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      if (!in_valid || !in_stall) begin
        if (in_valid) expected_results.push_back(access_result(in_data));
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap <= calm ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall and monitor
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= calm ? 0 : gap_len();
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (out_data.irq_raised) irqs_seen++;
          if (out_data.read_data !== e.read_data || out_data.irq_raised !== e.irq_raised) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: read_data exp %h got %h, irq exp %b got %b",
                       results_seen, e.read_data, out_data.read_data, e.irq_raised,
                       out_data.irq_raised);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results pending", expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int p, k, w;
    ctl_q = '0; deb_q = '0; sy_q = '0; sx_q = '0; dcy_q = '0; dcx_q = '0;
    dy_q = '0; dx_q = '0; status_q = '0;

    // Directed: registers, store extremes, vblank, unused actions
    reg_wr(REG_DEB, 16'hffff); reg_wr(REG_DX, 16'h0000);
    for (int i = 0; i < 8; i++) push_item(ACT_REG_RD, 16'(i), 16'h0, 16'h0);
    reg_wr(16'd8, 16'h1234);
    push_item(ACT_REG_RD, 16'hffff, 16'h0, 16'h0);
    push_item(ACT_MEM_WR, 16'hffff, 16'hffff, 16'hffff);
    push_item(ACT_MEM_WR, 16'h0000, 16'ha5a5, 16'h0ff0);
    push_item(ACT_MEM_RD, 16'hffff, 16'h0, 16'h0);
    push_item(ACT_MEM_RD, 16'h0000, 16'h0, 16'h0);
    push_item(ACT_VB_START, 16'h0, 16'h0, 16'h0);
    reg_wr(REG_CTRL, 16'h1 << CTL_FRM_IRQ);
    push_item(ACT_VB_START, 16'h0, 16'h0, 16'h0);
    push_item(ACT_REG_RD, REG_CTRL, 16'h0, 16'h0);
    push_item(ACT_VB_END, 16'h0, 16'h0, 16'h0);
    push_item(ACT_SPARE6, 16'hffff, 16'hffff, 16'hffff);
    push_item(ACT_SPARE7, 16'h0001, 16'h0, 16'h0);
    // Copy across the store's end with split writes, decrementing, interrupt on
    set_rect(16'h0007, 16'd0, 16'd3, 16'h1ffe, 16'h003d, 16'd1023, 16'd4090);
    reg_wr(REG_CTRL, 16'h8010);
    // Empty line width: origins still move
    set_rect(16'h0000, 16'd5, 16'd5, 16'h1fff, 16'hffff, 16'd5, 16'd15);
    reg_wr(REG_CTRL, 16'h8000);
    // Widest single line, then tallest fill with an empty line width
    set_rect(16'h000f, 16'd0, 16'd0, 16'hffff, 16'h0000, 16'd40, 16'd0);
    reg_wr(REG_CTRL, 16'h800c);
    set_rect(16'h0003, 16'd0, 16'd0, 16'h0000, 16'hffff, 16'd0, 16'd9);
    reg_wr(REG_CTRL, 16'h800e);
    for (int i = 0; i < 8; i++) push_item(ACT_REG_RD, 16'(i), 16'h0, 16'h0);

    // Random part: mostly well-formed blit setups over a small window of the store
    while (pending_items.size() < ITEM_TARGET + 60) begin
      p = $urandom_range(0, 99);
      if (p < 30) begin
        k = $urandom_range(0, 7);
        w = $urandom_range(0, 3);
        set_rect(16'($urandom), 16'($urandom_range(0, 24)),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023)),
                 {3'($urandom), 13'(13'h1fff - k)}, {10'($urandom), 6'(6'h3f - w)},
                 16'($urandom_range(0, 24)),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023)));
        reg_wr(REG_CTRL, 16'h8000 | 16'($urandom));
        if ($urandom_range(0, 1)) push_item(ACT_REG_RD, REG_CTRL, 16'($urandom), 16'h0);
      end else if (p < 50) begin
        push_item(ACT_MEM_WR,
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047)),
                  16'($urandom), 16'($urandom));
      end else if (p < 65) begin
        push_item(ACT_MEM_RD,
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047)),
                  16'($urandom), 16'($urandom));
      end else if (p < 78) begin
        push_item(ACT_REG_RD, ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)),
                  16'($urandom), 16'($urandom));
      end else if (p < 84) begin
        reg_wr(16'($urandom_range(0, 7)), 16'($urandom) & 16'h7fff);
      end else if (p < 90) begin
        push_item(ACT_VB_START, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (p < 95) begin
        push_item(ACT_VB_END, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (p < 97) begin
        push_item(ACT_REG_WR, 16'($urandom_range(8, 65535)), 16'($urandom), 16'($urandom));
      end else begin
        push_item($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7, 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d accesses checked, %0d blits run, %0d interrupts raised",
             results_seen, blits_run, irqs_seen);
    $display("%0d mismatches, %0d results still pending", mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== mono_frame_buffer_bit_blitter.f =====
+incdir+design
design/mfbb_pkg.sv
design/mfbb_dp.sv
design/mfbb_ctrl.sv
design/mono_frame_buffer_bit_blitter.sv
tb/sv/tb_mono_frame_buffer_bit_blitter.sv
